// File: src/vnh_pkg.sv
// Package: transaction types and constants for the value noise height block.
`timescale 1ns / 1ps
package vnh_pkg;

    localparam int COORD_BITS = 16;
    // Scaled position width: coordinate times a 14-bit scale, signed.
    localparam int POS_W      = COORD_BITS + 15;
    localparam int OCT_LAT    = 9;

    localparam logic [31:0] SALT_ONE = 32'h9E37_79B9;
    localparam logic [31:0] SALT_TWO = 32'h00A5_C3E5;
    localparam logic [31:0] HASH_C1  = 32'h9E37_79B9;
    localparam logic [31:0] HASH_C2  = 32'h85EB_CA6B;
    localparam logic [31:0] HASH_C3  = 32'hC2B2_AE35;
    localparam logic [31:0] HASH_C4  = 32'h27D4_EB0F;
    localparam logic [31:0] HASH_C5  = 32'h1656_67B1;

    localparam logic signed [POS_W-1:0] SCALE_ONE = POS_W'(3604);
    localparam logic signed [POS_W-1:0] SCALE_TWO = POS_W'(9732);

    localparam logic [3:0]  HEIGHT_BASE = 4'd3;
    // floor(v/3) = (v * RECIP3) >> 19 for v < 2^19
    localparam logic [17:0] RECIP3 = 18'd174763;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] col_x;
        logic signed [COORD_BITS-1:0] col_z;
    } col_t;

    typedef struct packed {
        logic [3:0]  height;
        logic [15:0] noise_level;
    } res_t;

endpackage

// File: src/vnh_octave.sv
// One octave of hashed value noise, fixed nine-stage pipeline.
`timescale 1ns / 1ps
module vnh_octave
    import vnh_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [31:0]             oct_seed,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_z,
    output logic [15:0]             noise
);

    logic [31:0] x0, x1, z0, z1;
    logic [15:0] tx, tz;

    // stage 2
    logic [31:0] hx_reg [2];
    logic [31:0] hz_reg [2];
    logic [31:0] ttx_reg, ttz_reg;
    logic [15:0] tx_reg, tz_reg;
    // stage 3
    logic [31:0] ha_reg [2];
    logic [31:0] hz3_reg [2];
    logic [15:0] ex3_reg, ez3_reg;
    // stages 4..6
    logic [31:0] hb_reg [2][2];
    logic [31:0] hc_reg [2][2];
    logic [15:0] cv_reg [2][2];
    logic [15:0] ex4_reg, ez4_reg, ex5_reg, ez5_reg, ex6_reg, ez6_reg;
    // stages 7..10
    logic signed [33:0] pt_reg, pb_reg;
    logic [15:0] at_reg, ab_reg, ez7_reg;
    logic [15:0] top_reg, bot_reg, ez8_reg;
    logic signed [33:0] pn_reg;
    logic [15:0] top9_reg;
    logic [15:0] n_reg;

    logic [17:0] wx, wz;
    logic [49:0] ex_full, ez_full;
    logic [31:0] hc_next [2][2];
    logic [31:0] hd [2][2];
    logic signed [33:0] pt_next, pb_next, pn_next;
    logic [15:0] top_next, bot_next, n_next;

    assign tx = pos_x[15:0];
    assign tz = pos_z[15:0];
    assign x0 = 32'($signed(pos_x[POS_W-1:16]));
    assign z0 = 32'($signed(pos_z[POS_W-1:16]));
    assign x1 = x0 + 32'd1;
    assign z1 = z0 + 32'd1;

    // smoothstep: t*t*(3*2^16 - 2t) >> 32
    assign wx = 18'd196608 - {1'b0, tx_reg, 1'b0};
    assign wz = 18'd196608 - {1'b0, tz_reg, 1'b0};
    assign ex_full = 50'(ttx_reg) * 50'(wx);
    assign ez_full = 50'(ttz_reg) * 50'(wz);

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                hc_next[j][i] = (hb_reg[j][i] ^ (hb_reg[j][i] >> 15)) * HASH_C5;
                hd[j][i]      = hc_reg[j][i] ^ (hc_reg[j][i] >> 13);
            end
        end
    end

    assign pt_next = $signed(17'({1'b0, cv_reg[0][1]}) - 17'({1'b0, cv_reg[0][0]}))
                   * $signed({1'b0, ex6_reg});
    assign pb_next = $signed(17'({1'b0, cv_reg[1][1]}) - 17'({1'b0, cv_reg[1][0]}))
                   * $signed({1'b0, ex6_reg});
    assign top_next = at_reg + pt_reg[31:16];
    assign bot_next = ab_reg + pb_reg[31:16];
    assign pn_next = $signed(17'({1'b0, bot_reg}) - 17'({1'b0, top_reg}))
                   * $signed({1'b0, ez8_reg});
    assign n_next = top9_reg + pn_reg[31:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg[0] <= x0 * HASH_C1;
            hx_reg[1] <= x1 * HASH_C1;
            hz_reg[0] <= z0 * HASH_C3;
            hz_reg[1] <= z1 * HASH_C3;
            ttx_reg   <= 32'(tx) * 32'(tx);
            ttz_reg   <= 32'(tz) * 32'(tz);
            tx_reg    <= tx;
            tz_reg    <= tz;

            ha_reg[0] <= (oct_seed ^ hx_reg[0]) * HASH_C2;
            ha_reg[1] <= (oct_seed ^ hx_reg[1]) * HASH_C2;
            hz3_reg   <= hz_reg;
            ex3_reg   <= ex_full[47:32];
            ez3_reg   <= ez_full[47:32];

            for (int j = 0; j < 2; j++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    hb_reg[j][i] <= (ha_reg[i] ^ hz3_reg[j]) * HASH_C4;
                    hc_reg[j][i] <= hc_next[j][i];
                    cv_reg[j][i] <= hd[j][i][15:0];
                end
            end
            ex4_reg <= ex3_reg;
            ez4_reg <= ez3_reg;
            ex5_reg <= ex4_reg;
            ez5_reg <= ez4_reg;
            ex6_reg <= ex5_reg;
            ez6_reg <= ez5_reg;

            pt_reg  <= pt_next;
            pb_reg  <= pb_next;
            at_reg  <= cv_reg[0][0];
            ab_reg  <= cv_reg[1][0];
            ez7_reg <= ez6_reg;

            top_reg <= top_next;
            bot_reg <= bot_next;
            ez8_reg <= ez7_reg;

            pn_reg   <= pn_next;
            top9_reg <= top_reg;

            n_reg <= n_next;
        end
    end

    assign noise = n_reg;

endmodule

// File: src/value_noise_height.sv
// Top level: two-octave value noise terrain height pipeline.
//
// Usage:
//   Input channel col / col_valid / col_stall carries one world column
//   (col_x, col_z) per transaction. Output channel res / res_valid /
//   res_stall returns one height and noise level per column, in order.
//   The seed is written through cfg_we / cfg_wdata; the user must
//   write it only while idle, as the block does not enforce this.
// Throughput: one column per cycle when not stalled; 13 register
//   stages, set by the hash multiply chain and the two blend levels.
// Stall: the whole pipeline holds while a result waits with res_stall
//   high; col_stall is then high, nothing is lost or repeated.
// Reset: rst_n clears the seed to zero and all stage valid bits; no
//   results are pending after reset.
`timescale 1ns / 1ps
module value_noise_height
    import vnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        col_valid,
    output logic        col_stall,
    input  col_t        col,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res
);

    localparam int DEPTH = OCT_LAT + 4;

    logic [31:0] seed_reg;
    logic [DEPTH-1:0] vld_reg;
    logic adv;

    col_t col_reg;
    logic signed [POS_W-1:0] p1x_reg, p1z_reg, p2x_reg, p2z_reg;
    logic [15:0] n1, n2;
    logic [3:0]  height_reg;
    logic [35:0] lvl_prod_reg;
    res_t res_reg;

    logic [31:0] s1, s2;
    logic signed [POS_W-1:0] cx, cz;
    logic [19:0] sum;
    logic [17:0] lvl_sum;

    assign adv       = !(vld_reg[DEPTH-1] && res_stall);
    assign col_stall = !adv;
    assign s1 = seed_reg ^ SALT_ONE;
    assign s2 = s1 ^ SALT_TWO;
    assign cx = POS_W'(col_reg.col_x);
    assign cz = POS_W'(col_reg.col_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[DEPTH-2:0], col_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg <= col;
            p1x_reg <= cx * SCALE_ONE;
            p1z_reg <= cz * SCALE_ONE;
            p2x_reg <= cx * SCALE_TWO;
            p2z_reg <= cz * SCALE_TWO;
            height_reg   <= HEIGHT_BASE + sum[19:16];
            lvl_prod_reg <= 36'(lvl_sum) * 36'(RECIP3);
            res_reg.height      <= height_reg;
            res_reg.noise_level <= lvl_prod_reg[34:19];
        end
    end

    vnh_octave u_oct1 (
        .clk      (clk),
        .en       (adv),
        .oct_seed (s1),
        .pos_x    (p1x_reg),
        .pos_z    (p1z_reg),
        .noise    (n1)
    );

    vnh_octave u_oct2 (
        .clk      (clk),
        .en       (adv),
        .oct_seed (s2),
        .pos_x    (p2x_reg),
        .pos_z    (p2z_reg),
        .noise    (n2)
    );

    // 8*n1 + 4*n2 and 2*n1 + n2
    assign sum     = {1'b0, n1, 3'b000} + {2'b00, n2, 2'b00};
    assign lvl_sum = {1'b0, n1, 1'b0} + {2'b00, n2};

    assign res_valid = vld_reg[DEPTH-1];
    assign res       = res_reg;

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.height >= 4'd3 && res.height <= 4'd14))
        else $error("height out of range");

    // height and level derive from the same 2*n1+n2 sum
    a_height_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({16'd0, res.height} >= 20'd3 + ((20'd12 * {4'd0, res.noise_level}) >> 16)
                    && {16'd0, res.height}
                       <= 20'd3 + ((20'd12 * {4'd0, res.noise_level} + 20'd8) >> 16)))
        else $error("height inconsistent with noise level");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_reg))
        else $error("stalled result lost");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        col_stall |-> res_valid)
        else $error("input stalled with no pending result");

endmodule

// File: test/tb_value_noise_height.sv
// Testbench: value_noise_height checked against a built-in height predictor.
`timescale 1ns / 1ps
module tb_value_noise_height;
    import vnh_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 30;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        col_valid;
    logic        col_stall;
    col_t        col;
    logic        res_valid;
    logic        res_stall;
    res_t        res;

    logic [31:0] seed_now;
    res_t        heights_due[$];
    int          mismatches;
    int          cycles;
    bit          idle_on;

    value_noise_height DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .col_valid(col_valid), .col_stall(col_stall), .col(col),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] lattice_hash(logic [31:0] s, logic [31:0] x,
                                                 logic [31:0] z);
        logic [31:0] h;
        h = (s ^ (x * HASH_C1)) * HASH_C2;
        h = (h ^ (z * HASH_C3)) * HASH_C4;
        h = h ^ (h >> 15);
        h = h * HASH_C5;
        h = h ^ (h >> 13);
        return h;
    endfunction

    function automatic longint smooth(longint t);
        return (t * t * (196608 - 2 * t)) >>> 32;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> 16);
    endfunction

    function automatic longint octave_noise(logic [31:0] s, longint px, longint pz);
        longint fx, fz, tx, tz, top, bot;
        logic [31:0] x0, z0;
        fx = px & 64'hFFFF;
        fz = pz & 64'hFFFF;
        x0 = 32'((px - fx) >>> 16);
        z0 = 32'((pz - fz) >>> 16);
        tx = smooth(fx);
        tz = smooth(fz);
        top = lerp_q16(lattice_hash(s, x0, z0) & 32'hFFFF,
                       lattice_hash(s, x0 + 1, z0) & 32'hFFFF, tx);
        bot = lerp_q16(lattice_hash(s, x0, z0 + 1) & 32'hFFFF,
                       lattice_hash(s, x0 + 1, z0 + 1) & 32'hFFFF, tx);
        return lerp_q16(top, bot, tz);
    endfunction

    function automatic res_t column_height(col_t c, logic [31:0] sd);
        longint x, z, n1, n2, h;
        logic [31:0] s1;
        res_t r;
        x = longint'(c.col_x);
        z = longint'(c.col_z);
        s1 = sd ^ SALT_ONE;
        n1 = octave_noise(s1, x * 3604, z * 3604);
        n2 = octave_noise(s1 ^ SALT_TWO, x * 9732, z * 9732);
        h = 3 + ((8 * n1 + 4 * n2) >>> 16);
        if (h > 14)
            h = 14;
        r.height = 4'(h);
        r.noise_level = 16'((2 * n1 + n2) / 3);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_column(logic signed [15:0] x, logic signed [15:0] z);
        col_t c;
        c.col_x = x;
        c.col_z = z;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            col_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        col_valid <= 1'b1;
        col <= c;
        @(posedge clk);
        while (col_stall)
            @(posedge clk);
        heights_due.push_back(column_height(c, seed_now));
    endtask

    task automatic load_seed(logic [31:0] sd);
        col_valid <= 1'b0;
        @(posedge clk);
        while (heights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= sd;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_now = sd;
    endtask

    // stall bursts on the result side
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (heights_due.size() == 0)
                report_mismatch("result with no transaction pending");
            else
            begin
                res_t e;
                e = heights_due.pop_front();
                if (res.height !== e.height)
                    report_mismatch($sformatf("height got %0d exp %0d",
                                              res.height, e.height));
                if (res.noise_level !== e.noise_level)
                    report_mismatch($sformatf("noise_level got %0d exp %0d",
                                              res.noise_level, e.noise_level));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_reset_seed();
        send_column(16'sd0, 16'sd0);
        send_column(16'sd1, -16'sd1);
        send_column(-16'sd32768, 16'sd32767);
    endtask

    task automatic test_extremes();
        logic signed [15:0] edges [6] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1,
                                          16'sd18, 16'sd32767};
        load_seed(32'hFFFF_FFFF);
        foreach (edges[i])
            send_column(edges[i], edges[5 - i]);
        send_column(16'sd32767, 16'sd32767);
        send_column(-16'sd32768, -16'sd32768);
        // seed equal to the salt zeroes the first octave seed
        load_seed(SALT_ONE);
        send_column(16'sd0, 16'sd0);
        send_column(16'sd7, -16'sd7);
        send_column(-16'sd32768, 16'sd0);
        load_seed(SALT_ONE ^ SALT_TWO);
        send_column(16'sd5, 16'sd9);
        send_column(16'sd32767, -16'sd32768);
    endtask

    task automatic test_random(int count);
        logic signed [15:0] x, z;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                x = 16'($urandom);
                z = 16'($urandom);
            end
            else
            begin
                x = 16'(int'($urandom_range(0, 400)) - 200);
                z = 16'(int'($urandom_range(0, 400)) - 200);
            end
            send_column(x, z);
        end
    endtask

    task automatic test_seed_sweep();
        for (int p = 0; p < 6; p++)
        begin
            load_seed($urandom);
            test_random(200);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        col_valid = 1'b0;
        col = '0;
        seed_now = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_seed();
        test_extremes();
        test_seed_sweep();
        load_seed(32'h0000_0000);
        test_random(40);
        idle_on = 1'b0;
        test_random(110);
        col_valid <= 1'b0;
        while (heights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
